[src/kwl_pkg.sv]
// Shared types, constants and helper functions for the keyword token lexer.
// Used by kwl_keyword_unit, kwl_out_fifo and keyword_token_lexer_unit.
// Depends on nothing else.
package kwl_pkg;

	localparam int OFFSET_BITS = 32;
	localparam int MAX_LEXEME = 255;
	localparam int LEN_BITS = 8;
	localparam int KIND_BITS = 5;
	localparam int CHAR_BITS = 8;
	localparam int START_BITS = 32;
	localparam int NUM_KEYWORDS = 22;
	localparam int KW_MAX_CHARS = 10;
	localparam int KW_LEN_BITS = 4;
	localparam int NUM_FLAGS = 4;

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_BITS = $clog2(FIFO_DEPTH + 1);

	typedef logic [KIND_BITS-1:0] kind_t;
	typedef logic [CHAR_BITS-1:0] char_t;
	typedef logic [LEN_BITS-1:0] len_t;
	typedef logic [OFFSET_BITS-1:0] offset_t;
	typedef logic [NUM_KEYWORDS-1:0] cand_t;
	typedef logic [NUM_FLAGS-1:0] flags_t;

	localparam kind_t KIND_LABEL = 5'd22;
	localparam kind_t KIND_STRING = 5'd23;
	localparam kind_t KIND_DOUBLE = 5'd24;
	localparam kind_t KIND_INTEGER = 5'd25;
	localparam kind_t KIND_IDENT = 5'd26;
	localparam kind_t KIND_END = 5'd27;

	// Input item kinds.
	localparam logic ITEM_CHAR = 1'b0;
	localparam logic ITEM_END = 1'b1;

	localparam char_t CH_LBRACKET = 8'h5B;
	localparam char_t CH_RBRACKET = 8'h5D;
	localparam char_t CH_QUOTE = 8'h22;
	localparam char_t CH_MINUS = 8'h2D;
	localparam char_t CH_DOT = 8'h2E;
	localparam char_t CH_SPACE = 8'h20;
	localparam char_t CH_TAB = 8'h09;
	localparam char_t CH_CR = 8'h0D;
	localparam char_t CH_ZERO = 8'h30;
	localparam char_t CH_NINE = 8'h39;

	// Bit positions in the number flags.
	localparam int NF_FIRST_DIGIT = 0;
	localparam int NF_FIRST_MINUS = 1;
	localparam int NF_SECOND_DIGIT = 2;
	localparam int NF_DOT = 3;

	localparam cand_t ALL_CANDIDATES = '1;

	// Keyword text, right-justified in each entry.
	localparam logic [KW_MAX_CHARS*CHAR_BITS-1:0] KW_TEXT [NUM_KEYWORDS] = '{
		"PUSH.INT", "PUSH.STR", "PUSH.DBL", "READ.INT", "READ.STR", "READ.DBL",
		"ADD", "SUB", "MUL", "DIV", "EXP", "MOD", "POP", "SWAP", "STORE", "LOAD",
		"PULL", "JMP.EQ.0", "JMP.GT.0", "JMP", "PRINT", "STR.CONCAT"
	};

	localparam logic [KW_LEN_BITS-1:0] KW_LEN [NUM_KEYWORDS] = '{
		4'd8, 4'd8, 4'd8, 4'd8, 4'd8, 4'd8, 4'd3, 4'd3, 4'd3, 4'd3, 4'd3,
		4'd3, 4'd3, 4'd4, 4'd5, 4'd4, 4'd4, 4'd8, 4'd8, 4'd3, 4'd5, 4'd10
	};

	typedef enum logic [3:0] {
		MODE_IDLE = 4'b0001,
		MODE_WORD = 4'b0010,
		MODE_LABEL = 4'b0100,
		MODE_STRING = 4'b1000
	} scan_mode_t;

	typedef struct packed {
		kind_t token_kind;
		logic [START_BITS-1:0] start_offset;
		len_t lexeme_length;
		logic too_long;
		logic last;
	} result_t;

	typedef struct packed {
		logic [FIFO_CNT_BITS-1:0] level;
		logic near_full;
	} fifo_status_t;

	function automatic logic is_space(input char_t c);
		is_space = (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
	endfunction

	function automatic logic is_digit(input char_t c);
		is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
	endfunction

	// Byte idx of keyword k; zero past the end of the keyword.
	function automatic char_t kw_byte(input int k, input len_t idx);
		int sh;
		sh = (int'(KW_LEN[k]) - 1 - int'(idx)) * CHAR_BITS;
		if (int'(idx) < int'(KW_LEN[k])) begin
			kw_byte = KW_TEXT[k][sh +: CHAR_BITS];
		end else begin
			kw_byte = '0;
		end
	endfunction

endpackage

[src/kwl_keyword_unit.sv]
// Keyword candidate update, number flag update and word classification.
// Pure combinational logic on the lexer's token state.
// Depends on kwl_pkg.
module kwl_keyword_unit (
	input  kwl_pkg::cand_t  cand,
	input  kwl_pkg::len_t   len,
	input  logic            overflow,
	input  kwl_pkg::flags_t flags,
	input  kwl_pkg::char_t  char_code,
	output kwl_pkg::cand_t  cand_next,
	output kwl_pkg::flags_t flags_next,
	output kwl_pkg::kind_t  word_kind
);

	logic found;

	// Each keyword stays a candidate only while the new byte matches it at this index.
	always_comb begin
		for (int k = 0; k < kwl_pkg::NUM_KEYWORDS; k++) begin
			cand_next[k] = cand[k] && !overflow &&
				(int'(len) < int'(kwl_pkg::KW_LEN[k])) &&
				(kwl_pkg::kw_byte(k, len) == char_code);
		end
	end

	always_comb begin
		flags_next = flags;
		if (len == '0) begin
			if (kwl_pkg::is_digit(char_code)) begin
				flags_next[kwl_pkg::NF_FIRST_DIGIT] = 1'b1;
			end
			if (char_code == kwl_pkg::CH_MINUS) begin
				flags_next[kwl_pkg::NF_FIRST_MINUS] = 1'b1;
			end
		end else if (len == kwl_pkg::len_t'(1) && !overflow && kwl_pkg::is_digit(char_code)) begin
			flags_next[kwl_pkg::NF_SECOND_DIGIT] = 1'b1;
		end
		if (char_code == kwl_pkg::CH_DOT) begin
			flags_next[kwl_pkg::NF_DOT] = 1'b1;
		end
	end

	always_comb begin
		found = 1'b0;
		word_kind = kwl_pkg::KIND_IDENT;
		for (int k = 0; k < kwl_pkg::NUM_KEYWORDS; k++) begin
			if (!found && cand[k] && !overflow &&
				(len == kwl_pkg::len_t'(kwl_pkg::KW_LEN[k]))) begin
				word_kind = kwl_pkg::kind_t'(k);
				found = 1'b1;
			end
		end
		if (!found && (flags[kwl_pkg::NF_FIRST_DIGIT] ||
			(flags[kwl_pkg::NF_FIRST_MINUS] && flags[kwl_pkg::NF_SECOND_DIGIT]))) begin
			word_kind = flags[kwl_pkg::NF_DOT] ? kwl_pkg::KIND_DOUBLE : kwl_pkg::KIND_INTEGER;
		end
	end

endmodule

[src/kwl_out_fifo.sv]
// Small result queue in flip-flops: takes up to two results a cycle, gives one.
// Reports its level and whether it can still take two more.
// Depends on kwl_pkg.
module kwl_out_fifo (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic [1:0]             push_cnt,
	input  kwl_pkg::result_t       push_a,
	input  kwl_pkg::result_t       push_b,
	input  logic                   pop,
	output logic                   head_valid,
	output kwl_pkg::result_t       head,
	output kwl_pkg::fifo_status_t  status
);

	kwl_pkg::result_t entries_q [kwl_pkg::FIFO_DEPTH];
	logic [kwl_pkg::FIFO_PTR_BITS-1:0] wr_ptr_q;
	logic [kwl_pkg::FIFO_PTR_BITS-1:0] rd_ptr_q;
	logic [kwl_pkg::FIFO_CNT_BITS-1:0] count_q;
	logic [kwl_pkg::FIFO_PTR_BITS-1:0] wr_ptr_b;
	logic do_pop;

	assign wr_ptr_b = kwl_pkg::FIFO_PTR_BITS'(wr_ptr_q + 1'b1);
	assign head_valid = (count_q != '0);
	assign head = entries_q[rd_ptr_q];
	assign do_pop = pop && head_valid;

	assign status.level = count_q;
	assign status.near_full = (count_q > kwl_pkg::FIFO_CNT_BITS'(kwl_pkg::FIFO_DEPTH - 2));

	always_ff @(posedge clk) begin
		if (push_cnt != 2'd0) begin
			entries_q[wr_ptr_q] <= push_a;
		end
		if (push_cnt == 2'd2) begin
			entries_q[wr_ptr_b] <= push_b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			wr_ptr_q <= kwl_pkg::FIFO_PTR_BITS'(wr_ptr_q + push_cnt);
			if (do_pop) begin
				rd_ptr_q <= kwl_pkg::FIFO_PTR_BITS'(rd_ptr_q + 1'b1);
			end
			count_q <= kwl_pkg::FIFO_CNT_BITS'(count_q + push_cnt - {2'b00, do_pop});
		end
	end

endmodule

[src/keyword_token_lexer_unit.sv]
// Top level of the keyword token lexer: token state machine and result queue.
// Depends on kwl_pkg, kwl_keyword_unit and kwl_out_fifo.
//
//  Channel | Direction | Handshake          | Payload
//  in      | input     | in_valid/in_stall   | kind, char_code
//  out     | output    | out_valid/out_stall | token_kind, start_offset, lexeme_length,
//          |           |                     | too_long, last
//
// One item is taken per cycle while in_stall is low; each updates the token state and
// queues zero, one or two results, the earliest visible the cycle after if the queue was empty.
// Results leave through a four-entry queue, one per cycle while out_stall is low; in_stall rises while
// it holds more than two, so a stalled output backs up into the input.
// arst_n clears the token state, the offset and the queue.
module keyword_token_lexer_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic                            kind,
	input  logic [kwl_pkg::CHAR_BITS-1:0]   char_code,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [kwl_pkg::KIND_BITS-1:0]   token_kind,
	output logic [kwl_pkg::START_BITS-1:0]  start_offset,
	output logic [kwl_pkg::LEN_BITS-1:0]    lexeme_length,
	output logic                            too_long,
	output logic                            last
);

	kwl_pkg::scan_mode_t mode_q, mode_n;
	kwl_pkg::offset_t pos_q, pos_n;
	kwl_pkg::offset_t start_q, start_n;
	kwl_pkg::len_t len_q, len_n;
	logic ovf_q, ovf_n;
	kwl_pkg::cand_t cand_q, cand_n;
	kwl_pkg::flags_t flags_q, flags_n;

	kwl_pkg::cand_t cand_upd;
	kwl_pkg::flags_t flags_upd;
	kwl_pkg::kind_t word_kind;

	logic accept;
	logic do_append;
	logic word_byte;
	logic do_clear;
	logic pending;
	logic [1:0] push_cnt;
	kwl_pkg::result_t push_a, push_b;
	kwl_pkg::result_t flush_res, end_res, head;
	kwl_pkg::fifo_status_t fifo_status;
	logic head_valid;

	kwl_keyword_unit u_keyword (
		.cand       (cand_q),
		.len        (len_q),
		.overflow   (ovf_q),
		.flags      (flags_q),
		.char_code  (char_code),
		.cand_next  (cand_upd),
		.flags_next (flags_upd),
		.word_kind  (word_kind)
	);

	assign accept = in_valid && !in_stall;
	assign pending = (mode_q != kwl_pkg::MODE_IDLE) && (len_q != '0);

	always_comb begin
		flush_res.start_offset = kwl_pkg::START_BITS'(start_q);
		flush_res.lexeme_length = len_q;
		flush_res.too_long = ovf_q;
		flush_res.last = 1'b1;
		case (mode_q)
			kwl_pkg::MODE_WORD: flush_res.token_kind = word_kind;
			kwl_pkg::MODE_LABEL: flush_res.token_kind = kwl_pkg::KIND_LABEL;
			default: flush_res.token_kind = kwl_pkg::KIND_STRING;
		endcase
	end

	always_comb begin
		end_res.token_kind = kwl_pkg::KIND_END;
		end_res.start_offset = kwl_pkg::START_BITS'(pos_q);
		end_res.lexeme_length = '0;
		end_res.too_long = 1'b0;
		end_res.last = 1'b1;
	end

	always_comb begin
		mode_n = mode_q;
		pos_n = pos_q;
		start_n = start_q;
		len_n = len_q;
		ovf_n = ovf_q;
		cand_n = cand_q;
		flags_n = flags_q;
		do_append = 1'b0;
		word_byte = 1'b0;
		do_clear = 1'b0;
		push_cnt = 2'd0;
		push_a = flush_res;
		push_b = end_res;

		if (accept) begin
			if (kind == kwl_pkg::ITEM_END) begin
				// The pending token, if any, goes out ahead of the end token.
				if (pending) begin
					push_cnt = 2'd2;
					push_a.last = 1'b0;
				end else begin
					push_cnt = 2'd1;
					push_a = end_res;
				end
				do_clear = 1'b1;
				mode_n = kwl_pkg::MODE_IDLE;
				pos_n = '0;
				start_n = '0;
			end else begin
				pos_n = kwl_pkg::OFFSET_BITS'(pos_q + 1'b1);
				case (mode_q)
					kwl_pkg::MODE_IDLE: begin
						if (kwl_pkg::is_space(char_code)) begin
							mode_n = kwl_pkg::MODE_IDLE;
						end else if (char_code == kwl_pkg::CH_LBRACKET) begin
							mode_n = kwl_pkg::MODE_LABEL;
							start_n = kwl_pkg::OFFSET_BITS'(pos_q + 1'b1);
						end else if (char_code == kwl_pkg::CH_QUOTE) begin
							mode_n = kwl_pkg::MODE_STRING;
							start_n = kwl_pkg::OFFSET_BITS'(pos_q + 1'b1);
						end else begin
							mode_n = kwl_pkg::MODE_WORD;
							start_n = pos_q;
							do_append = 1'b1;
							word_byte = 1'b1;
						end
					end
					kwl_pkg::MODE_WORD: begin
						if (kwl_pkg::is_space(char_code)) begin
							push_cnt = 2'd1;
							do_clear = 1'b1;
							mode_n = kwl_pkg::MODE_IDLE;
						end else begin
							do_append = 1'b1;
							word_byte = 1'b1;
						end
					end
					kwl_pkg::MODE_LABEL: begin
						if (char_code == kwl_pkg::CH_RBRACKET) begin
							push_cnt = {1'b0, pending};
							do_clear = 1'b1;
							mode_n = kwl_pkg::MODE_IDLE;
						end else begin
							do_append = 1'b1;
						end
					end
					kwl_pkg::MODE_STRING: begin
						if (char_code == kwl_pkg::CH_QUOTE) begin
							push_cnt = {1'b0, pending};
							do_clear = 1'b1;
							mode_n = kwl_pkg::MODE_IDLE;
						end else begin
							do_append = 1'b1;
						end
					end
					default: begin
						do_clear = 1'b1;
						mode_n = kwl_pkg::MODE_IDLE;
					end
				endcase
			end
		end

		if (do_clear) begin
			len_n = '0;
			ovf_n = 1'b0;
			cand_n = kwl_pkg::ALL_CANDIDATES;
			flags_n = '0;
		end else if (do_append) begin
			if (len_q < kwl_pkg::LEN_BITS'(kwl_pkg::MAX_LEXEME)) begin
				len_n = kwl_pkg::LEN_BITS'(len_q + 1'b1);
			end else begin
				ovf_n = 1'b1;
			end
			if (word_byte) begin
				cand_n = cand_upd;
				flags_n = flags_upd;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= kwl_pkg::MODE_IDLE;
			pos_q <= '0;
			start_q <= '0;
			len_q <= '0;
			ovf_q <= 1'b0;
			cand_q <= kwl_pkg::ALL_CANDIDATES;
			flags_q <= '0;
		end else begin
			mode_q <= mode_n;
			pos_q <= pos_n;
			start_q <= start_n;
			len_q <= len_n;
			ovf_q <= ovf_n;
			cand_q <= cand_n;
			flags_q <= flags_n;
		end
	end

	kwl_out_fifo u_out_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_cnt   (push_cnt),
		.push_a     (push_a),
		.push_b     (push_b),
		.pop        (!out_stall),
		.head_valid (head_valid),
		.head       (head),
		.status     (fifo_status)
	);

	assign in_stall = fifo_status.near_full;
	assign out_valid = head_valid;
	assign token_kind = head.token_kind;
	assign start_offset = head.start_offset;
	assign lexeme_length = head.lexeme_length;
	assign too_long = head.too_long;
	assign last = head.last;

	// The queue never holds more than its depth.
	assert property (@(posedge clk) disable iff (!arst_n)
		fifo_status.level <= kwl_pkg::FIFO_CNT_BITS'(kwl_pkg::FIFO_DEPTH))
		else $error("result queue overfilled");

	// An end item returns the lexer to offset zero between tokens.
	assert property (@(posedge clk) disable iff (!arst_n)
		(accept && kind == kwl_pkg::ITEM_END) |=>
		(pos_q == '0 && mode_q == kwl_pkg::MODE_IDLE && len_q == '0))
		else $error("end item did not restart the lexer");

	// The overflow flag is only set once the length has saturated.
	assert property (@(posedge clk) disable iff (!arst_n)
		ovf_q |-> (len_q == kwl_pkg::LEN_BITS'(kwl_pkg::MAX_LEXEME)))
		else $error("overflow without saturated length");

	// Between tokens the token state is clear.
	assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == kwl_pkg::MODE_IDLE) |->
		(len_q == '0 && !ovf_q && cand_q == kwl_pkg::ALL_CANDIDATES && flags_q == '0))
		else $error("token state not clear while idle");

endmodule

[test/tb_top.sv]
`timescale 1ns / 100ps
// Self-checking testbench for keyword_token_lexer_unit: byte stream in, tokens out.
// Depends on kwl_pkg and the lexer RTL; a local token predictor or a directed row's expected token checks every result.

module tb_top;
	import kwl_pkg::*;

	localparam int DIR_ROWS = 25;
	localparam int RAND_ITEMS = 1850;
	localparam int CALM_TAIL = 200;
	localparam int WD_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 20;

	localparam kind_t KIND_KW_ADD = 5'd6;

	localparam result_t NO_TOKEN = '0;
	localparam result_t EOF_AT_0 = '{KIND_END, 32'd0, 8'd0, 1'b0, 1'b1};
	localparam result_t ADD_AT_0 = '{KIND_KW_ADD, 32'd0, 8'd3, 1'b0, 1'b1};
	localparam result_t DBL_AT_4 = '{KIND_DOUBLE, 32'd4, 8'd3, 1'b0, 1'b1};
	localparam result_t STR_AT_11 = '{KIND_STRING, 32'd11, 8'd1, 1'b0, 1'b1};

	typedef enum int {
		TK_KEYWORD, TK_INTEGER, TK_DOUBLE, TK_IDENT, TK_LABEL, TK_STRING,
		TK_NOISE, TK_END, TK_LONG_WORD
	} tok_shape_t;

	typedef struct {
		logic is_end;
		char_t ch;
		bit typed;
		result_t want;
	} stim_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic kind = ITEM_CHAR;
	char_t char_code = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	kind_t token_kind;
	logic [START_BITS-1:0] start_offset;
	len_t lexeme_length;
	logic too_long;
	logic last;

	string kw_names [NUM_KEYWORDS] = '{
		"PUSH.INT", "PUSH.STR", "PUSH.DBL", "READ.INT", "READ.STR", "READ.DBL",
		"ADD", "SUB", "MUL", "DIV", "EXP", "MOD", "POP", "SWAP", "STORE", "LOAD",
		"PULL", "JMP.EQ.0", "JMP.GT.0", "JMP", "PRINT", "STR.CONCAT"
	};

	// Predicted lexer state.
	scan_mode_t lx_mode;
	offset_t lx_pos;
	offset_t lx_start;
	int lx_len;
	logic lx_ovf;
	cand_t lx_cand;
	flags_t lx_nf;

	result_t step_toks [$];
	result_t tokens_due [$];
	stim_t stim_q [$];
	stim_t dir_tab [DIR_ROWS];

	int stim_idx = 0;
	int in_gap = 0;
	int out_gap = 0;
	int quiet_cycles = 0;
	int errors = 0;
	int n_in = 0;
	int n_tok = 0;
	int n_end = 0;
	int n_long = 0;
	bit cur_typed = 1'b0;
	result_t cur_want = '0;
	bit calm;

	keyword_token_lexer_unit u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.kind(kind),
		.char_code(char_code),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.token_kind(token_kind),
		.start_offset(start_offset),
		.lexeme_length(lexeme_length),
		.too_long(too_long),
		.last(last)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic bit is_blank(input char_t c);
		return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
	endfunction

	function automatic bit is_num(input char_t c);
		return c >= CH_ZERO && c <= CH_NINE;
	endfunction

	task automatic tok_clear();
		lx_len = 0;
		lx_ovf = 1'b0;
		lx_cand = ALL_CANDIDATES;
		lx_nf = '0;
	endtask

	task automatic lex_reset();
		lx_mode = MODE_IDLE;
		lx_pos = '0;
		lx_start = '0;
		tok_clear();
	endtask

	task automatic tok_append(input char_t c);
		int k;
		if (lx_mode == MODE_WORD) begin
			for (k = 0; k < NUM_KEYWORDS; k++) begin
				if (lx_cand[k] && (lx_ovf || lx_len >= kw_names[k].len() ||
						char_t'(kw_names[k][lx_len]) != c)) begin
					lx_cand[k] = 1'b0;
				end
			end
			if (lx_len == 0) begin
				if (is_num(c)) lx_nf[NF_FIRST_DIGIT] = 1'b1;
				if (c == CH_MINUS) lx_nf[NF_FIRST_MINUS] = 1'b1;
			end else if (lx_len == 1 && !lx_ovf && is_num(c)) begin
				lx_nf[NF_SECOND_DIGIT] = 1'b1;
			end
			if (c == CH_DOT) lx_nf[NF_DOT] = 1'b1;
		end
		if (lx_len < MAX_LEXEME) begin
			lx_len++;
		end else begin
			lx_ovf = 1'b1;
		end
	endtask

	function automatic kind_t word_class();
		int k;
		for (k = 0; k < NUM_KEYWORDS; k++) begin
			if (lx_cand[k] && !lx_ovf && lx_len == kw_names[k].len()) return kind_t'(k);
		end
		if (lx_nf[NF_FIRST_DIGIT] || (lx_nf[NF_FIRST_MINUS] && lx_nf[NF_SECOND_DIGIT])) begin
			return lx_nf[NF_DOT] ? KIND_DOUBLE : KIND_INTEGER;
		end
		return KIND_IDENT;
	endfunction

	task automatic add_tok(input kind_t k, input offset_t st, input len_t n, input logic ovf);
		result_t r;
		r.token_kind = k;
		r.start_offset = st;
		r.lexeme_length = n;
		r.too_long = ovf;
		r.last = 1'b0;
		step_toks.push_back(r);
	endtask

	// Empty lexemes (such as an empty label or string) give no token.
	task automatic emit_pending();
		kind_t k;
		if (lx_mode != MODE_IDLE && lx_len != 0) begin
			if (lx_mode == MODE_WORD) k = word_class();
			else if (lx_mode == MODE_LABEL) k = KIND_LABEL;
			else k = KIND_STRING;
			add_tok(k, lx_start, len_t'(lx_len), lx_ovf);
		end
	endtask

	task automatic lex_item(input logic is_end, input char_t c);
		char_t closing;
		step_toks.delete();
		if (is_end == ITEM_END) begin
			emit_pending();
			add_tok(KIND_END, lx_pos, '0, 1'b0);
			lex_reset();
		end else begin
			case (lx_mode)
				MODE_IDLE: begin
					tok_clear();
					if (!is_blank(c)) begin
						if (c == CH_LBRACKET) begin
							lx_mode = MODE_LABEL;
							lx_start = lx_pos + 1'b1;
						end else if (c == CH_QUOTE) begin
							lx_mode = MODE_STRING;
							lx_start = lx_pos + 1'b1;
						end else begin
							lx_mode = MODE_WORD;
							lx_start = lx_pos;
							tok_append(c);
						end
					end
				end
				MODE_WORD: begin
					if (is_blank(c)) begin
						emit_pending();
						lx_mode = MODE_IDLE;
						tok_clear();
					end else begin
						tok_append(c);
					end
				end
				default: begin
					closing = (lx_mode == MODE_LABEL) ? CH_RBRACKET : CH_QUOTE;
					if (c == closing) begin
						emit_pending();
						lx_mode = MODE_IDLE;
						tok_clear();
					end else begin
						tok_append(c);
					end
				end
			endcase
			lx_pos = lx_pos + 1'b1;
		end
		if (step_toks.size() > 0) step_toks[step_toks.size() - 1].last = 1'b1;
	endtask

	task automatic push_ch(input char_t c);
		stim_t s;
		s.is_end = ITEM_CHAR;
		s.ch = c;
		s.typed = 1'b0;
		s.want = NO_TOKEN;
		stim_q.push_back(s);
	endtask

	function automatic char_t solid_byte();
		char_t b;
		do b = char_t'($urandom_range(0, 255)); while (is_blank(b));
		return b;
	endfunction

	// One token of the given shape followed by zero to two blanks; size > 0
	// fixes the lexeme length of labels, strings and long words.
	task automatic gen_token(input tok_shape_t shape, input int size);
		int n;
		int i;
		char_t b;
		char_t open_ch;
		char_t close_ch;
		string w;
		stim_t s;
		case (shape)
			TK_KEYWORD: begin
				w = kw_names[$urandom_range(0, NUM_KEYWORDS - 1)];
				n = w.len();
				i = $urandom_range(0, 9);
				// Mostly exact keywords, some cut short, with one byte changed or with one byte added.
				if (i == 7) n = n - 1;
				if (i == 8) w[$urandom_range(0, n - 1)] = byte'($urandom_range(33, 126));
				for (i = 0; i < n; i++) push_ch(char_t'(w[i]));
				if ($urandom_range(0, 9) == 0) push_ch(solid_byte());
			end
			TK_INTEGER, TK_DOUBLE: begin
				if ($urandom_range(0, 2) == 0) push_ch(CH_MINUS);
				n = $urandom_range(1, 6);
				for (i = 0; i < n; i++) push_ch(CH_ZERO + char_t'($urandom_range(0, 9)));
				if (shape == TK_DOUBLE) begin
					push_ch(CH_DOT);
					n = $urandom_range(0, 4);
					for (i = 0; i < n; i++) push_ch(CH_ZERO + char_t'($urandom_range(0, 9)));
				end
			end
			TK_IDENT: begin
				n = $urandom_range(1, 8);
				push_ch(char_t'($urandom_range(65, 90)));
				for (i = 1; i < n; i++) push_ch(solid_byte());
			end
			TK_LABEL, TK_STRING: begin
				open_ch = (shape == TK_LABEL) ? CH_LBRACKET : CH_QUOTE;
				close_ch = (shape == TK_LABEL) ? CH_RBRACKET : CH_QUOTE;
				n = (size > 0) ? size : $urandom_range(0, 6);
				push_ch(open_ch);
				for (i = 0; i < n; i++) begin
					do b = char_t'($urandom_range(0, 255)); while (b == close_ch);
					push_ch(b);
				end
				if ($urandom_range(0, 7) != 0) push_ch(close_ch);
			end
			TK_NOISE: begin
				n = $urandom_range(1, 4);
				for (i = 0; i < n; i++) push_ch(char_t'($urandom_range(0, 255)));
			end
			TK_END: begin
				s.is_end = ITEM_END;
				s.ch = char_t'($urandom_range(0, 255));
				s.typed = 1'b0;
				s.want = NO_TOKEN;
				stim_q.push_back(s);
			end
			default: begin
				// A number-like word of size bytes ending in '.'; the '.' lies past the length limit when size > MAX_LEXEME.
				push_ch(CH_MINUS);
				for (i = 1; i < size - 1; i++) push_ch(CH_ZERO + char_t'($urandom_range(0, 9)));
				push_ch(CH_DOT);
			end
		endcase
		n = $urandom_range(0, 2);
		for (i = 0; i < n; i++) begin
			push_ch(($urandom_range(0, 5) == 5) ? CH_SPACE : CH_TAB + char_t'($urandom_range(0, 4)));
		end
	endtask

	task automatic chk(input string field, input logic [31:0] e, input logic [31:0] a);
		if (e !== a) begin
			$error("%s: expected %0d, got %0d", field, e, a);
			errors++;
		end
	endtask

	assign calm = (stim_idx + CALM_TAIL >= stim_q.size());

	always @(posedge clk) begin
		result_t w;
		int i;
		bit took_in;
		bit took_out;
		if (arst_n) begin
			took_in = in_valid && !in_stall;
			took_out = out_valid && !out_stall;
			if (took_in) begin
				lex_item(kind, char_code);
				if (cur_typed) begin
					tokens_due.push_back(cur_want);
				end else begin
					for (i = 0; i < step_toks.size(); i++) tokens_due.push_back(step_toks[i]);
				end
				n_in++;
			end
			if (took_out) begin
				if (tokens_due.size() == 0) begin
					$error("token with no item pending: kind %0d offset %0d", token_kind,
						start_offset);
					errors++;
				end else begin
					w = tokens_due.pop_front();
					chk("token_kind", w.token_kind, token_kind);
					chk("start_offset", w.start_offset, start_offset);
					chk("lexeme_length", w.lexeme_length, lexeme_length);
					chk("too_long", w.too_long, too_long);
					chk("last", w.last, last);
				end
				n_tok++;
				if (token_kind == KIND_END) n_end++;
				if (too_long) n_long++;
			end
			quiet_cycles <= (took_in || took_out) ? 0 : quiet_cycles + 1;

			// A stalled item holds; otherwise present the next one or idle.
			if (!(in_valid && in_stall)) begin
				if (in_gap > 0) begin
					in_gap--;
					in_valid <= 1'b0;
				end else if (!calm && $urandom_range(0, 5) == 0) begin
					in_gap = $urandom_range(0, 3);
					in_valid <= 1'b0;
				end else if (stim_idx < stim_q.size()) begin
					in_valid <= 1'b1;
					kind <= stim_q[stim_idx].is_end;
					char_code <= stim_q[stim_idx].ch;
					cur_typed <= stim_q[stim_idx].typed;
					cur_want <= stim_q[stim_idx].want;
					stim_idx++;
				end else begin
					in_valid <= 1'b0;
				end
			end

			if (out_gap > 0) begin
				out_gap--;
				out_stall <= 1'b1;
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				out_gap = $urandom_range(0, 3);
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	initial begin
		int i;
		int r;
		tok_shape_t shape;
		lex_reset();
		dir_tab = '{
			'{ITEM_END, 8'h00, 1'b1, EOF_AT_0},
			'{ITEM_CHAR, "A", 1'b0, NO_TOKEN},
			'{ITEM_CHAR, "D", 1'b0, NO_TOKEN},
			'{ITEM_CHAR, "D", 1'b0, NO_TOKEN},
			'{ITEM_CHAR, CH_SPACE, 1'b1, ADD_AT_0},
			'{ITEM_CHAR, CH_MINUS, 1'b0, NO_TOKEN},
			'{ITEM_CHAR, "7", 1'b0, NO_TOKEN},
			'{ITEM_CHAR, CH_DOT, 1'b0, NO_TOKEN},
			'{ITEM_CHAR, CH_TAB, 1'b1, DBL_AT_4},
			'{ITEM_CHAR, CH_LBRACKET, 1'b0, NO_TOKEN},
			'{ITEM_CHAR, CH_RBRACKET, 1'b0, NO_TOKEN},
			'{ITEM_CHAR, CH_QUOTE, 1'b0, NO_TOKEN},
			'{ITEM_CHAR, 8'h00, 1'b0, NO_TOKEN},
			'{ITEM_CHAR, CH_QUOTE, 1'b1, STR_AT_11},
			'{ITEM_CHAR, 8'hFF, 1'b0, NO_TOKEN},
			'{ITEM_CHAR, CH_QUOTE, 1'b0, NO_TOKEN},
			'{ITEM_CHAR, CH_CR, 1'b0, NO_TOKEN},
			'{ITEM_CHAR, CH_LBRACKET, 1'b0, NO_TOKEN},
			'{ITEM_CHAR, CH_SPACE, 1'b0, NO_TOKEN},
			'{ITEM_CHAR, CH_RBRACKET, 1'b0, NO_TOKEN},
			'{ITEM_CHAR, "1", 1'b0, NO_TOKEN},
			'{ITEM_END, 8'hFF, 1'b0, NO_TOKEN},
			'{ITEM_CHAR, CH_QUOTE, 1'b0, NO_TOKEN},
			'{ITEM_CHAR, "q", 1'b0, NO_TOKEN},
			'{ITEM_END, 8'h00, 1'b0, NO_TOKEN}
		};
		for (i = 0; i < DIR_ROWS; i++) stim_q.push_back(dir_tab[i]);

		// Length limit on each side of the boundary, then mostly short tokens.
		gen_token(TK_LONG_WORD, MAX_LEXEME + 2);
		gen_token(TK_LABEL, MAX_LEXEME);
		gen_token(TK_STRING, MAX_LEXEME + 1);
		while (stim_q.size() < DIR_ROWS + RAND_ITEMS) begin
			r = $urandom_range(0, 99);
			if (r < 30) shape = TK_KEYWORD;
			else if (r < 42) shape = TK_INTEGER;
			else if (r < 50) shape = TK_DOUBLE;
			else if (r < 62) shape = TK_IDENT;
			else if (r < 72) shape = TK_LABEL;
			else if (r < 82) shape = TK_STRING;
			else if (r < 95) shape = TK_NOISE;
			else shape = TK_END;
			if ($urandom_range(0, 149) == 0) begin
				gen_token(($urandom_range(0, 1) == 0) ? TK_LONG_WORD : TK_STRING,
					$urandom_range(250, 260));
			end else begin
				gen_token(shape, 0);
			end
		end
		gen_token(TK_END, 0);

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		while (!(stim_idx == stim_q.size() && !in_valid && tokens_due.size() == 0) &&
				quiet_cycles < WD_LIMIT) begin
			@(posedge clk);
		end
		if (quiet_cycles >= WD_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end else begin
			repeat (DRAIN_CYCLES) @(posedge clk);
			$display("Lexed %0d input items into %0d tokens, %0d of them end tokens.",
				n_in, n_tok, n_end);
			$display("Overlong lexemes seen: %0d; mismatches: %0d.", n_long, errors);
			if (errors == 0 && tokens_due.size() == 0) begin
				$display("*** PASSED ***");
			end else begin
				$display("*** FAILED ***");
			end
			$finish;
		end
	end

endmodule

[keyword_token_lexer_unit.f]
src/kwl_pkg.sv
src/kwl_keyword_unit.sv
src/kwl_out_fifo.sv
src/keyword_token_lexer_unit.sv
test/tb_top.sv
